@@ rtl/plist_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// plist_pkg: shared types and constants for the positional list unit
// Field widths, operation and status codes, and the per-cell control word.
// ---------------------------------------------------------------------------
package plist_pkg;

  // field widths fixed by the interface
  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;
  localparam int LEN_W   = 7;

  // operation codes carried on in_func
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // control word for one storage cell, already qualified by the accept
  typedef struct packed {
    logic ins_here;    // load the incoming value
    logic from_left;   // take the lower neighbor's entry (insert shift)
    logic from_right;  // take the upper neighbor's entry (delete close-up)
  } cell_ctrl_t;

endpackage : plist_pkg
`default_nettype wire

@@ rtl/plist_cell.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// plist_cell: one storage cell of the list chain
// Holds one entry; loads the new value or its left or right neighbor's entry.
// ---------------------------------------------------------------------------
module plist_cell (
  input  wire                                   clk,
  input  plist_pkg::cell_ctrl_t                 ctrl,
  input  wire  [plist_pkg::VALUE_W-1:0]         in_value,
  input  wire  [plist_pkg::VALUE_W-1:0]         left_data,
  input  wire  [plist_pkg::VALUE_W-1:0]         right_data,
  output logic [plist_pkg::VALUE_W-1:0]         data_q
);

  logic [plist_pkg::VALUE_W-1:0] data_r;

  // entry register, payload only: no reset
  always_ff @(posedge clk) begin
    priority if (ctrl.ins_here) begin
      data_r <= in_value;
    end else if (ctrl.from_left) begin
      data_r <= left_data;
    end else if (ctrl.from_right) begin
      data_r <= right_data;
    end
  end

  assign data_q = data_r;

endmodule : plist_cell
`default_nettype wire

@@ rtl/positional_list_insert_delete_unit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// positional_list_insert_delete_unit: ordered list with positional insert/delete
// Row of shifting cells; every word gives one result with status and length.
// ---------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells; an insert or a delete shifts the
// affected cells by one place in the clock edge that accepts the word, so a
// new word can be taken every cycle while in_stall is low. Each result passes
// a pipeline stage, then the output register: the removed value is picked out
// of the cells by a two-level registered OR tree (groups of 32 cells, then the
// group results). Status and length are decided from the entry count, position
// and function alone. An output register with a pipeline stage in front lets
// input words keep coming while a result waits for the consumer; in_stall
// rises only when both stages are full and out_stall is high. Cells need no
// clearing after reset: only entries below the count are ever read.
// ---------------------------------------------------------------------------
module positional_list_insert_delete_unit #(
  parameter int CAPACITY = 64
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // input words
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire                                   in_func,
  input  wire  [plist_pkg::POS_W-1:0]           in_position,
  input  wire  signed [plist_pkg::VALUE_W-1:0]  in_value,
  // result words
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [plist_pkg::VALUE_W-1:0]  out_removed_value,
  output logic [1:0]                            out_status,
  output logic [plist_pkg::LEN_W-1:0]           out_length
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > plist_pkg::POS_W) ? CW : plist_pkg::POS_W;
  localparam int GS = 32;
  localparam int NG = (CAPACITY + GS - 1) / GS;
  localparam int NP = NG * GS;
  localparam int VW = plist_pkg::VALUE_W;

  // control and count
  logic                     in_acc;
  logic                     out_free;
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic [PW-1:0]            pos_ext;
  logic [PW-1:0]            cnt_ext;
  logic                     ins_ok;
  logic                     del_ok;
  plist_pkg::status_t       status_c;

  // cells and removal tree
  logic [VW-1:0]            cell_data [CAPACITY];
  logic [VW-1:0]            data_pad  [NP];
  logic                     hit_pad   [NP];
  logic [VW-1:0]            grp_c     [NG];
  logic [VW-1:0]            rem_c;

  // pipeline registers
  logic                     s1_valid_r;
  plist_pkg::status_t       s1_status_r;
  logic [plist_pkg::LEN_W-1:0] s1_length_r;
  logic [VW-1:0]            group_r   [NG];
  logic                     out_valid_r;
  plist_pkg::status_t       out_status_r;
  logic [plist_pkg::LEN_W-1:0] out_length_r;
  logic [VW-1:0]            out_removed_r;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign pos_ext = PW'(in_position);
  assign cnt_ext = PW'(count_r);

  // operation decode from the entry count and the position
  always_comb begin
    ins_ok    = 1'b0;
    del_ok    = 1'b0;
    status_c  = plist_pkg::ST_OK;
    count_nxt = count_r;
    if (in_func == plist_pkg::FUNC_INSERT) begin
      if (pos_ext > cnt_ext) begin
        status_c = plist_pkg::ST_BAD_POS;
      end else if (count_r == CW'(CAPACITY)) begin
        status_c = plist_pkg::ST_FULL;
      end else begin
        ins_ok    = 1'b1;
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (count_r == '0) begin
        status_c = plist_pkg::ST_EMPTY;
      end else if (pos_ext >= cnt_ext) begin
        status_c = plist_pkg::ST_BAD_POS;
      end else begin
        del_ok    = 1'b1;
        count_nxt = count_r - 1'b1;
      end
    end
  end

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [PW-1:0] IDX = PW'(i);
    plist_pkg::cell_ctrl_t ctrl;
    logic [VW-1:0]         left_d;
    logic [VW-1:0]         right_d;

    assign ctrl.ins_here   = in_acc && ins_ok && (IDX == pos_ext);
    assign ctrl.from_left  = in_acc && ins_ok && (IDX > pos_ext);
    assign ctrl.from_right = in_acc && del_ok && (IDX >= pos_ext);

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    plist_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .in_value   (in_value),
      .left_data  (left_d),
      .right_data (right_d),
      .data_q     (cell_data[i])
    );

    assign data_pad[i] = cell_data[i];
    assign hit_pad[i]  = del_ok && (IDX == pos_ext);
  end

  // pad the last group up to a full group
  for (genvar p = CAPACITY; p < NP; p++) begin : g_pad
    assign data_pad[p] = '0;
    assign hit_pad[p]  = 1'b0;
  end

  // first tree level: one OR per group of cells
  for (genvar g = 0; g < NG; g++) begin : g_grp
    always_comb begin
      grp_c[g] = '0;
      for (int k = 0; k < GS; k++) begin
        if (hit_pad[g*GS + k]) begin
          grp_c[g] = grp_c[g] | data_pad[g*GS + k];
        end
      end
    end
  end

  // second tree level: combine the registered groups
  always_comb begin
    rem_c = '0;
    for (int g = 0; g < NG; g++) begin
      rem_c = rem_c | group_r[g];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r <= count_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (out_free) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // result payload stages
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_status_r <= status_c;
      s1_length_r <= plist_pkg::LEN_W'(count_nxt);
      for (int g = 0; g < NG; g++) begin
        group_r[g] <= grp_c[g];
      end
    end
    if (s1_valid_r && out_free) begin
      out_status_r  <= s1_status_r;
      out_length_r  <= s1_length_r;
      out_removed_r <= rem_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_length        = out_length_r;
  assign out_removed_value = out_removed_r;

`ifndef SYNTHESIS
  // count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // only a successful delete returns a value
  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != plist_pkg::ST_OK) |-> out_removed_r == '0)
    else $error("nonzero removed value on failed operation");

  // a successful insert grows the list by one
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ins_ok |=> count_r == CW'($past(count_r) + 1'b1))
    else $error("insert did not grow the count");

  // a successful delete shrinks the list by one
  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && del_ok |=> count_r == CW'($past(count_r) - 1'b1))
    else $error("delete did not shrink the count");

  // input stalls only when both result stages hold words
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");
`endif

endmodule : positional_list_insert_delete_unit
`default_nettype wire
